// ----- rtl/core/asbp_pkg.sv -----
// asbp_pkg: transaction payload types and status codes of the allocation profiler
// used by alloc_stack_bucket_profiler, no dependencies
package asbp_pkg;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_address;
    logic [31:0] block_size;
    logic [7:0]  call_depth;
    logic [63:0] frame_address;
    logic        last_item;
  } asbp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  bucket_index;
    logic [63:0] stack_hash;
    logic        address_tracked;
    logic [31:0] alloc_objects;
    logic [31:0] free_objects;
  } asbp_out_t;

  localparam logic [2:0] ST_EXIST   = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_OFF     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_FREE    = 3'd4;
  localparam logic [2:0] ST_FREEUNK = 3'd5;

  localparam logic MODE_FREE = 1'b1;

endpackage

// ----- rtl/core/alloc_stack_bucket_profiler.sv -----
// alloc_stack_bucket_profiler: stack-hash bucket table with allocation and free counters
// depends on asbp_pkg
//
// usage: allocation events arrive on the input channel as one transaction per stack
// frame, the last one flagged by last_item; a free event is a single transaction.
// one result transaction leaves for every free and for every closing allocation item.
// the configuration channel sets sampling_enable and is always ready.
// timing: the block takes one transaction at a time and is not ready while it works.
// a stored frame runs a three-step hash mix on one shared 64-bit unit.
// a closing item pads each missing frame into the hash, finalizes it, folds it into a
// slot, reads the slot head, walks the chain comparing each bucket and its frames or
// opens a new bucket and copies its frames, updates the counters, then searches the
// address table entry by entry; with sampling off the slot and bucket steps are skipped.
// a free searches the address table entry by entry, then counts the free in its bucket.
// all tables are single-port memories with registered reads.
// reset empties all slot chains, the bucket store and the address table at once
// (counts, no clearing pass) and clears sampling_enable.
// a result waits in an output register while the receiver stalls; new input is
// still taken, and the next result waits until the register is free.
module alloc_stack_bucket_profiler
  import asbp_pkg::*;
#(
  parameter int HASH_SLOTS      = 256,
  parameter int MAX_FRAMES      = 32,
  parameter int BUCKET_ENTRIES  = 256,
  parameter int ADDRESS_ENTRIES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  asbp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output asbp_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  localparam int SW  = $clog2(HASH_SLOTS);
  localparam int FW  = $clog2(MAX_FRAMES + 1);
  localparam int FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int BW  = $clog2(BUCKET_ENTRIES);
  localparam int BCW = $clog2(BUCKET_ENTRIES + 1);
  localparam int AW  = $clog2(ADDRESS_ENTRIES);
  localparam int AW1 = $clog2(ADDRESS_ENTRIES + 1);
  localparam int FMW = $clog2(BUCKET_ENTRIES * MAX_FRAMES);
  localparam logic [SW:0] HS_L = (SW+1)'(HASH_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE, S_MIX, S_PAD, S_FIN, S_MOD, S_HEAD, S_HEAD2, S_HEAD3, S_CHK, S_CMP,
    S_FRQ, S_FRC, S_NEW, S_CPQ, S_CPW, S_CNT, S_CNT2, S_ASRCH, S_ACMP, S_AUPD,
    S_FB, S_FC, S_EMIT
  } state_e;

  typedef enum logic [1:0] {P_FREE, P_OFF, P_FULL, P_ALLOC} purp_e;

  state_e      state_q, ret_q;
  purp_e       purp_q;
  logic [1:0]  ph_q;
  logic [63:0] h_q, mixv_q, addr_q;
  logic [31:0] size_q;
  logic [FW-1:0] fr_q, dep_q, cnt_q;
  logic [SW-1:0] slot_q;
  logic [BW-1:0] cur_q, b_q;
  logic [BCW-1:0] bcnt_q;
  logic        isnew_q, hv_q, found_q, en_q, out_valid_q;
  logic [AW1-1:0] ai_q, fill_q;
  asbp_out_t   res_q, out_q;

  // memories
  logic [63:0]   fb_mem   [MAX_FRAMES];
  logic [BW-1:0] head_mem [HASH_SLOTS];
  logic [SW-1:0] bslot_mem[BUCKET_ENTRIES];
  logic [BW:0]   next_mem [BUCKET_ENTRIES];
  logic [63:0]   key_mem  [BUCKET_ENTRIES];
  logic [31:0]   size_mem [BUCKET_ENTRIES];
  logic [FW-1:0] cnt_mem  [BUCKET_ENTRIES];
  logic [63:0]   frm_mem  [BUCKET_ENTRIES * MAX_FRAMES];
  logic [31:0]   aobj_mem [BUCKET_ENTRIES];
  logic [31:0]   fobj_mem [BUCKET_ENTRIES];
  logic [63:0]   akey_mem [ADDRESS_ENTRIES];
  logic [BW-1:0] abkt_mem [ADDRESS_ENTRIES];

  logic [63:0]   rd_fb, rd_bf, rd_key, rd_akey;
  logic [BW-1:0] rd_head, rd_abkt;
  logic [SW-1:0] rd_bslot;
  logic [BW:0]   rd_next;
  logic [31:0]   rd_size, rd_aobj, rd_fobj;
  logic [FW-1:0] rd_cnt;

  logic          accept;
  logic [FW-1:0] dclamp;
  logic [SW:0]   slot_t;
  logic [SW-1:0] slot_d;
  logic [FMW-1:0] frm_addr;
  logic [63:0]   keyf;
  logic [63:0]   hfin;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dclamp = (in_data_i.call_depth > 8'(MAX_FRAMES)) ? FW'(MAX_FRAMES)
                                                          : FW'(in_data_i.call_depth);
  // equal hashes always share a slot, so low bits folded once into range serve
  assign slot_t = {1'b0, h_q[SW-1:0]};
  assign slot_d = (slot_t >= HS_L) ? SW'(slot_t - HS_L) : h_q[SW-1:0];
  assign frm_addr = FMW'((state_q == S_CPW) ? b_q : cur_q) * FMW'(MAX_FRAMES)
                  + FMW'(cnt_q);
  assign keyf   = (cnt_q < fr_q) ? rd_fb : 64'd0;
  assign hfin   = h_q ^ (h_q >> 11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      purp_q      <= P_FREE;
      ph_q        <= '0;
      h_q         <= '0;
      fr_q        <= '0;
      bcnt_q      <= '0;
      fill_q      <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) en_q <= cfg_data_i;
      if (out_ready_i && state_q != S_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            addr_q <= in_data_i.block_address;
            size_q <= in_data_i.block_size;
            dep_q  <= dclamp;
            if (in_data_i.mode == MODE_FREE) begin
              purp_q  <= P_FREE;
              ai_q    <= '0;
              state_q <= S_ASRCH;
            end else if (fr_q < dclamp) begin
              fr_q    <= fr_q + 1'b1;
              cnt_q   <= fr_q + 1'b1;
              mixv_q  <= in_data_i.frame_address;
              ph_q    <= '0;
              ret_q   <= in_data_i.last_item ? S_PAD : S_IDLE;
              state_q <= S_MIX;
            end else if (in_data_i.last_item) begin
              cnt_q   <= fr_q;
              state_q <= S_PAD;
            end
          end
        end
        S_MIX: begin
          case (ph_q)
            2'd0:    h_q <= h_q + mixv_q;
            2'd1:    h_q <= h_q + (h_q << 10);
            default: h_q <= h_q ^ (h_q >> 6);
          endcase
          if (ph_q == 2'd2) begin
            ph_q    <= '0;
            state_q <= ret_q;
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        S_PAD: begin
          ph_q    <= '0;
          state_q <= S_MIX;
          if (cnt_q < dep_q) begin
            cnt_q  <= cnt_q + 1'b1;
            mixv_q <= '0;
            ret_q  <= S_PAD;
          end else begin
            mixv_q <= 64'(size_q);
            ret_q  <= S_FIN;
          end
        end
        S_FIN: begin
          if (ph_q == 2'd0) begin
            h_q  <= h_q + (h_q << 3);
            ph_q <= 2'd1;
          end else begin
            ph_q  <= '0;
            h_q   <= hfin;
            res_q <= '{status: ST_OFF, stack_hash: hfin, default: '0};
            if (!en_q) begin
              purp_q  <= P_OFF;
              ai_q    <= '0;
              state_q <= S_ASRCH;
            end else begin
              state_q <= S_MOD;
            end
          end
        end
        S_MOD: begin
          slot_q  <= slot_d;
          state_q <= S_HEAD;
        end
        S_HEAD:  state_q <= S_HEAD2;
        S_HEAD2: begin
          cur_q   <= rd_head;
          state_q <= S_HEAD3;
        end
        S_HEAD3: begin
          if (BCW'(cur_q) < bcnt_q && rd_bslot == slot_q) begin
            hv_q    <= 1'b1;
            state_q <= S_CHK;
          end else begin
            hv_q    <= 1'b0;
            state_q <= S_NEW;
          end
        end
        S_CHK: state_q <= S_CMP;
        S_CMP: begin
          if (rd_key == h_q && rd_size == size_q && rd_cnt == dep_q) begin
            cnt_q   <= '0;
            state_q <= S_FRQ;
          end else if (rd_next[BW]) begin
            cur_q   <= rd_next[BW-1:0];
            state_q <= S_CHK;
          end else begin
            state_q <= S_NEW;
          end
        end
        S_FRQ: begin
          if (cnt_q == dep_q) begin
            b_q          <= cur_q;
            isnew_q      <= 1'b0;
            res_q.status <= ST_EXIST;
            state_q      <= S_CNT;
          end else begin
            state_q <= S_FRC;
          end
        end
        S_FRC: begin
          if (rd_bf == keyf) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_FRQ;
          end else if (rd_next[BW]) begin
            cur_q   <= rd_next[BW-1:0];
            state_q <= S_CHK;
          end else begin
            state_q <= S_NEW;
          end
        end
        S_NEW: begin
          if (bcnt_q >= BCW'(BUCKET_ENTRIES)) begin
            res_q.status <= ST_FULL;
            purp_q  <= P_FULL;
            ai_q    <= '0;
            state_q <= S_ASRCH;
          end else begin
            b_q          <= bcnt_q[BW-1:0];
            bcnt_q       <= bcnt_q + 1'b1;
            isnew_q      <= 1'b1;
            res_q.status <= ST_NEW;
            cnt_q        <= '0;
            state_q      <= S_CPQ;
          end
        end
        S_CPQ: state_q <= (cnt_q == dep_q) ? S_CNT : S_CPW;
        S_CPW: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_CPQ;
        end
        S_CNT: state_q <= S_CNT2;
        S_CNT2: begin
          res_q.alloc_objects <= isnew_q ? 32'd1 : rd_aobj + 32'd1;
          res_q.free_objects  <= isnew_q ? 32'd0 : rd_fobj;
          res_q.bucket_index  <= 8'(b_q);
          purp_q  <= P_ALLOC;
          ai_q    <= '0;
          state_q <= S_ASRCH;
        end
        S_ASRCH: begin
          if (ai_q < fill_q) begin
            state_q <= S_ACMP;
          end else begin
            found_q <= 1'b0;
            state_q <= S_AUPD;
          end
        end
        S_ACMP: begin
          if (rd_akey == addr_q) begin
            found_q <= 1'b1;
            state_q <= S_AUPD;
          end else begin
            ai_q    <= ai_q + 1'b1;
            state_q <= S_ASRCH;
          end
        end
        S_AUPD: begin
          case (purp_q)
            P_FREE: begin
              if (found_q) begin
                state_q <= S_FB;
              end else begin
                res_q   <= '{status: ST_FREEUNK, default: '0};
                state_q <= S_EMIT;
              end
            end
            P_ALLOC: begin
              if (found_q) begin
                res_q.address_tracked <= 1'b1;
              end else if (fill_q < AW1'(ADDRESS_ENTRIES)) begin
                res_q.address_tracked <= 1'b1;
                fill_q <= fill_q + 1'b1;
              end else begin
                res_q.address_tracked <= 1'b0;
              end
              state_q <= S_EMIT;
            end
            default: begin
              res_q.address_tracked <= found_q;
              state_q <= S_EMIT;
            end
          endcase
        end
        S_FB: begin
          b_q     <= rd_abkt;
          state_q <= S_FC;
        end
        S_FC: begin
          res_q.status          <= ST_FREE;
          res_q.bucket_index    <= 8'(b_q);
          res_q.stack_hash      <= rd_key;
          res_q.address_tracked <= 1'b1;
          res_q.alloc_objects   <= rd_aobj;
          res_q.free_objects    <= rd_fobj + 32'd1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            if (purp_q != P_FREE) begin
              fr_q <= '0;
              h_q  <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept && in_data_i.mode != MODE_FREE && fr_q < dclamp)
          fb_mem[fr_q[FIW-1:0]] <= in_data_i.frame_address;
      end
      S_HEAD:  rd_head  <= head_mem[slot_q];
      S_HEAD2: rd_bslot <= bslot_mem[rd_head];
      S_CHK: begin
        rd_key  <= key_mem[cur_q];
        rd_size <= size_mem[cur_q];
        rd_cnt  <= cnt_mem[cur_q];
        rd_next <= next_mem[cur_q];
      end
      S_FRQ: begin
        if (cnt_q != dep_q) begin
          rd_bf <= frm_mem[frm_addr];
          rd_fb <= fb_mem[cnt_q[FIW-1:0]];
        end
      end
      S_NEW: begin
        if (bcnt_q < BCW'(BUCKET_ENTRIES)) begin
          key_mem[bcnt_q[BW-1:0]]   <= h_q;
          size_mem[bcnt_q[BW-1:0]]  <= size_q;
          cnt_mem[bcnt_q[BW-1:0]]   <= dep_q;
          bslot_mem[bcnt_q[BW-1:0]] <= slot_q;
          next_mem[bcnt_q[BW-1:0]]  <= {hv_q, rd_head};
          head_mem[slot_q]          <= bcnt_q[BW-1:0];
        end
      end
      S_CPQ: if (cnt_q != dep_q) rd_fb <= fb_mem[cnt_q[FIW-1:0]];
      S_CPW: frm_mem[frm_addr] <= keyf;
      S_CNT: begin
        rd_aobj <= aobj_mem[b_q];
        rd_fobj <= fobj_mem[b_q];
      end
      S_CNT2: begin
        aobj_mem[b_q] <= isnew_q ? 32'd1 : rd_aobj + 32'd1;
        if (isnew_q) fobj_mem[b_q] <= 32'd0;
      end
      S_ASRCH: if (ai_q < fill_q) rd_akey <= akey_mem[ai_q[AW-1:0]];
      S_AUPD: begin
        if (purp_q == P_FREE) begin
          rd_abkt <= abkt_mem[ai_q[AW-1:0]];
        end else if (purp_q == P_ALLOC) begin
          if (found_q) begin
            abkt_mem[ai_q[AW-1:0]] <= b_q;
          end else if (fill_q < AW1'(ADDRESS_ENTRIES)) begin
            akey_mem[fill_q[AW-1:0]] <= addr_q;
            abkt_mem[fill_q[AW-1:0]] <= b_q;
          end
        end
      end
      S_FB: begin
        rd_key  <= key_mem[rd_abkt];
        rd_aobj <= aobj_mem[rd_abkt];
        rd_fobj <= fobj_mem[rd_abkt];
      end
      S_FC: fobj_mem[b_q] <= rd_fobj + 32'd1;
      default: ;
    endcase
  end

endmodule

// ----- dv/tb.sv -----
// tb: self-checking testbench of alloc_stack_bucket_profiler, stack hash buckets and free counts
// depends on asbp_pkg and the profiler rtl, scoreboard class holds its own bucket table
module tb
  import asbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 256;
  localparam int MAXF = 32;
  localparam int NBKT = 256;
  localparam int NADDR = 1024;
  localparam int NOLINK = 511;
  localparam longint LIMIT = 12_000_000;

  class profile_scoreboard;
    bit [63:0] fbuf [MAXF];
    int unsigned nrecv;
    bit [63:0] rhash;
    int unsigned head [NSLOT];
    int unsigned nxt [NBKT];
    bit [63:0] khash [NBKT];
    bit [31:0] ksize [NBKT];
    int unsigned kdepth [NBKT];
    bit [63:0] kframes [NBKT][MAXF];
    bit [31:0] aobj [NBKT];
    bit [31:0] abytes [NBKT];
    bit [31:0] fobj [NBKT];
    bit [31:0] fbytes [NBKT];
    int unsigned nbkt;
    bit [63:0] akey [NADDR];
    bit [7:0] abkt [NADDR];
    bit aval [NADDR];
    bit enable;
    asbp_out_t pending_results [$];
    int errors;

    function new();
      nrecv = 0;
      rhash = 0;
      nbkt = 0;
      enable = 0;
      errors = 0;
      foreach (head[i]) head[i] = NOLINK;
      foreach (aval[i]) aval[i] = 0;
      foreach (fbuf[i]) fbuf[i] = 0;
    endfunction

    function bit [63:0] mix(bit [63:0] h, bit [63:0] v);
      h = h + v;
      h = h + (h << 10);
      h = h ^ (h >> 6);
      return h;
    endfunction

    function int find_addr(bit [63:0] a);
      for (int i = 0; i < NADDR; i++)
        if (aval[i] && akey[i] == a) return i;
      return -1;
    endfunction

    function void note(asbp_in_t x);
      int unsigned d;
      int unsigned cur;
      int unsigned b;
      int ai;
      bit [63:0] h;
      bit [63:0] keyf [MAXF];
      bit hit;
      asbp_out_t r;
      r = '0;
      d = (x.call_depth > MAXF) ? MAXF : x.call_depth;
      if (x.mode == MODE_FREE) begin
        ai = find_addr(x.block_address);
        if (ai < 0) begin
          r.status = ST_FREEUNK;
        end else begin
          b = abkt[ai];
          fobj[b] += 1;
          fbytes[b] += x.block_size;
          r.status = ST_FREE;
          r.bucket_index = b[7:0];
          r.stack_hash = khash[b];
          r.address_tracked = 1'b1;
          r.alloc_objects = aobj[b];
          r.free_objects = fobj[b];
        end
        pending_results.push_back(r);
        return;
      end
      if (nrecv < d) begin
        fbuf[nrecv] = x.frame_address;
        rhash = mix(rhash, x.frame_address);
        nrecv++;
      end
      if (!x.last_item) return;
      h = rhash;
      for (int i = 0; i < d; i++) begin
        if (i < nrecv) begin
          keyf[i] = fbuf[i];
        end else begin
          keyf[i] = 0;
          h = mix(h, 64'd0);
        end
      end
      h = mix(h, {32'd0, x.block_size});
      h = h + (h << 3);
      h = h ^ (h >> 11);
      nrecv = 0;
      rhash = 0;
      r.stack_hash = h;
      if (!enable) begin
        r.status = ST_OFF;
        r.address_tracked = find_addr(x.block_address) >= 0;
        pending_results.push_back(r);
        return;
      end
      hit = 0;
      cur = head[h[7:0]];
      for (int g = 0; cur < NBKT && g < NBKT && !hit; g++) begin
        if (khash[cur] == h && ksize[cur] == x.block_size && kdepth[cur] == d) begin
          hit = 1;
          for (int i = 0; i < d; i++)
            if (kframes[cur][i] != keyf[i]) hit = 0;
        end
        if (hit) b = cur;
        else cur = nxt[cur];
      end
      r.status = ST_EXIST;
      if (!hit) begin
        if (nbkt >= NBKT) begin
          r.status = ST_FULL;
          r.address_tracked = find_addr(x.block_address) >= 0;
          pending_results.push_back(r);
          return;
        end
        b = nbkt++;
        khash[b] = h;
        ksize[b] = x.block_size;
        kdepth[b] = d;
        for (int i = 0; i < d; i++) kframes[b][i] = keyf[i];
        aobj[b] = 0;
        abytes[b] = 0;
        fobj[b] = 0;
        fbytes[b] = 0;
        nxt[b] = head[h[7:0]];
        head[h[7:0]] = b;
        r.status = ST_NEW;
      end
      aobj[b] += 1;
      abytes[b] += x.block_size;
      ai = find_addr(x.block_address);
      if (ai < 0) begin
        for (int i = 0; i < NADDR && ai < 0; i++)
          if (!aval[i]) ai = i;
      end
      if (ai >= 0) begin
        aval[ai] = 1;
        akey[ai] = x.block_address;
        abkt[ai] = b[7:0];
      end
      r.bucket_index = b[7:0];
      r.address_tracked = ai >= 0;
      r.alloc_objects = aobj[b];
      r.free_objects = fobj[b];
      pending_results.push_back(r);
    endfunction

    function void check(asbp_out_t a);
      asbp_out_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", a);
        return;
      end
      e = pending_results.pop_front();
      if (a.status != e.status || a.bucket_index != e.bucket_index ||
          a.stack_hash != e.stack_hash || a.address_tracked != e.address_tracked ||
          a.alloc_objects != e.alloc_objects || a.free_objects != e.free_objects) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch: exp st %0d bk %0d h %h at %0d ao %0d fo %0d",
                 e.status, e.bucket_index, e.stack_hash, e.address_tracked,
                 e.alloc_objects, e.free_objects);
          $display(" / got st %0d bk %0d h %h at %0d ao %0d fo %0d",
                   a.status, a.bucket_index, a.stack_hash, a.address_tracked,
                   a.alloc_objects, a.free_objects);
        end
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  asbp_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  asbp_out_t out_data_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic cfg_data_i = 0;

  profile_scoreboard sb = new();
  int idle_in = 0;
  int idle_out = 0;
  int hold_cycles = 0;
  longint cycles = 0;
  bit [63:0] addr_pool [128];
  bit [63:0] frame_pool [4][8];
  bit [31:0] size_pool [4];

  alloc_stack_bucket_profiler uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_out);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check(out_data_o);

  task automatic send(asbp_in_t x);
    while ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(x);
    @(negedge clk_i);
  endtask

  task automatic stop_in();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    stop_in();
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_sampling(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.enable = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // frames come from the pool row unless frames_rand is set
  task automatic send_alloc(bit [63:0] addr, bit [31:0] size, bit [7:0] depth,
                            int nitems, int row, bit frames_rand);
    asbp_in_t x;
    for (int i = 0; i < nitems; i++) begin
      x.mode = 1'b0;
      x.block_address = addr;
      x.block_size = size;
      x.call_depth = depth;
      x.frame_address = frames_rand ? {$urandom, $urandom} : frame_pool[row][i % 8];
      x.last_item = (i == nitems - 1);
      if (!x.last_item && $urandom_range(19) == 0) begin
        x.block_address = {$urandom, $urandom};
        x.block_size = $urandom;
      end
      send(x);
    end
  endtask

  task automatic send_free(bit [63:0] addr, bit [31:0] size);
    asbp_in_t x;
    x.mode = MODE_FREE;
    x.block_address = addr;
    x.block_size = size;
    x.call_depth = 8'($urandom);
    x.frame_address = {$urandom, $urandom};
    x.last_item = 1'b1;
    send(x);
  endtask

  task automatic random_item();
    int k;
    int d;
    int n;
    k = $urandom_range(99);
    if (k < 30) begin
      send_free(addr_pool[$urandom_range(127)], $urandom);
    end else if (k < 34) begin
      send_free({$urandom, $urandom}, $urandom);
    end else if (k < 37) begin
      send_alloc(addr_pool[$urandom_range(127)], $urandom, 8'($urandom), 1, 0, 1);
    end else begin
      d = $urandom_range(6);
      n = d + 1;
      if ($urandom_range(9) == 0) n = $urandom_range(1, d + 3);
      send_alloc(addr_pool[$urandom_range(127)], size_pool[$urandom_range(3)], 8'(d), n,
                 $urandom_range(3), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
    addr_pool[0] = '1;
    addr_pool[1] = '0;
    foreach (frame_pool[i, j]) frame_pool[i][j] = {$urandom, $urandom};
    size_pool = '{32'd16, 32'd0, 32'hFFFF_FFFF, $urandom};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sampling off, then on
    send_alloc(addr_pool[2], 32'd64, 8'd2, 3, 0, 0);
    send_free(addr_pool[2], 32'd64);
    drain();
    set_sampling(1'b1);
    send_alloc(addr_pool[0], 32'hFFFF_FFFF, 8'd0, 1, 0, 0);
    send_alloc(addr_pool[1], 32'd0, 8'd1, 1, 1, 0);
    send_alloc(addr_pool[3], 32'd16, 8'd3, 3, 2, 0);
    send_alloc(addr_pool[4], 32'd16, 8'd3, 3, 2, 0);
    send_alloc(addr_pool[5], 32'd16, 8'd5, 2, 2, 0);
    send_alloc(addr_pool[6], 32'd16, 8'd2, 6, 3, 0);
    send_alloc(addr_pool[7], 32'd8, 8'd255, 34, 0, 1);
    send_alloc(addr_pool[8], 32'd8, 8'd33, 33, 0, 1);
    send_free(addr_pool[3], 32'd16);
    send_free(addr_pool[3], 32'hFFFF_FFFF);
    send_free(64'h1234, 32'd1);
    // free of another address between two allocations of the same address
    send_alloc(addr_pool[9], 32'd4, 8'd3, 1, 1, 0);
    send_free(addr_pool[0], 32'd0);
    send_alloc(addr_pool[9], 32'd4, 8'd3, 2, 1, 0);
    drain();

    idle_in = 29;
    idle_out = 87;
    for (int i = 0; i < 150; i++) random_item();
    drain();
    set_sampling(1'b0);
    idle_in = 87;
    idle_out = 29;
    for (int i = 0; i < 40; i++) random_item();
    drain();
    set_sampling(1'b1);
    for (int i = 0; i < 110; i++) random_item();
    drain();

    idle_in = 0;
    idle_out = 0;
    // fill the bucket store, the tail of the run sees a full store
    for (int i = 0; i < 280; i++) begin
      if (i == 20) hold_cycles = 1500;
      send_alloc(addr_pool[$urandom_range(127)], $urandom, 8'd0, 1, 0, 0);
    end
    for (int i = 0; i < 120; i++) random_item();
    drain();
    set_sampling(1'b0);
    for (int i = 0; i < 20; i++) random_item();
    drain();

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- alloc_stack_bucket_profiler.f -----
rtl/core/asbp_pkg.sv
rtl/core/alloc_stack_bucket_profiler.sv
dv/tb.sv
